// ===== rtl/chu_pkg.sv =====
// Shared types, constants and rounding for the chroma 2x horizontal upsampler.
package chu_pkg;

    // Seven-sample window, samples i-3..i+3 around the position being output
    localparam int TAP_SPAN = 7;
    localparam int SAMPLE_W = 8;
    // Filter sums stay within -26520..91800 before rounding
    localparam int SUM_W    = 19;

    typedef logic [SAMPLE_W-1:0]           sample_t;
    typedef sample_t [TAP_SPAN-1:0]        window_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    // Per-cycle command from the control to every window cell
    typedef struct packed {
        logic fill;
        logic shift;
    } cell_ctl_t;

    // Filter taps
    localparam sum_t C5   = sum_t'(5);
    localparam sum_t C11  = sum_t'(11);
    localparam sum_t C21  = sum_t'(21);
    localparam sum_t C37  = sum_t'(37);
    localparam sum_t C52  = sum_t'(52);
    localparam sum_t C70  = sum_t'(70);
    localparam sum_t C159 = sum_t'(159);
    localparam sum_t C228 = sum_t'(228);
    localparam sum_t ROUND_BIAS = sum_t'(128);

    // Add the rounding bias, drop eight fraction bits and clamp to 0..255
    function automatic sample_t round_clamp(input sum_t sum);
        sum_t v;
        v = sum + ROUND_BIAS;
        if (v[SUM_W-1])
            return '0;
        else if (|v[SUM_W-2:SAMPLE_W+8])
            return '1;
        else
            return v[SAMPLE_W+7:8];
    endfunction

endpackage

// ===== rtl/chroma_horizontal_upsample_2x.sv =====
// Top level: window cell chain, flush control, filter and output register.
// Output: the pair for position i is formed once sample i+3 is in the window, then
// registered; after a row-end beat the flushed pairs follow one per cycle unless stalled.
// Throughput: one sample beat per cycle inside a row while the output is not stalled; a row-end
// beat holds the input while the window flushes its pending positions.
// Reset: mode returns to co-sited (1), row count to start of row, no pair valid.
module chroma_horizontal_upsample_2x (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  chu_pkg::sample_t chroma_sample,
    input  logic             row_end,
    output logic             pair_valid,
    input  logic             pair_stall,
    output chu_pkg::sample_t even_sample,
    output chu_pkg::sample_t odd_sample,
    output logic             row_last
);
    import chu_pkg::*;

    localparam logic [1:0] FILL_FULL   = 2'd3;
    localparam logic [1:0] FLUSH_STEPS = 2'd3;

    logic       mode_reg;
    logic [1:0] fill_count_reg, fill_count_next;
    logic [1:0] flush_left_reg, flush_left_next;
    logic [1:0] flush_n_reg, flush_n_next;
    logic       emit_pend_reg, emit_pend_next;
    logic       emit_last_reg, emit_last_next;
    logic       out_valid_reg, out_valid_next;
    sample_t    even_reg, odd_reg;
    logic       last_reg;

    logic       can_load;
    logic       slot_free;
    logic       emit_fire;
    logic       accept;
    logic       flush_fire;
    logic       flush_emit;
    cell_ctl_t  cell_ctl;
    sample_t    right_in;
    window_t    window;
    sample_t    filt_even, filt_odd;

    // Handshake decisions for this cycle
    always_comb
    begin
        can_load     = !out_valid_reg || !pair_stall;
        emit_fire    = emit_pend_reg && can_load;
        slot_free    = !emit_pend_reg || can_load;
        sample_stall = !((flush_left_reg == 2'd0) && slot_free);
        accept       = sample_valid && !sample_stall;
        flush_fire   = (flush_left_reg != 2'd0) && slot_free;
        flush_emit   = ({1'b0, flush_n_reg} + 3'd1) >= {1'b0, flush_left_reg};
    end

    // Drive the cell chain: fill at row start, otherwise shift in from the right
    always_comb
    begin
        cell_ctl.fill  = accept && (fill_count_reg == 2'd0);
        cell_ctl.shift = (accept && (fill_count_reg != 2'd0)) || flush_fire;
        right_in       = accept ? chroma_sample : window[TAP_SPAN-1];
    end

    genvar gi;
    generate
        for (gi = 0; gi < TAP_SPAN; gi++)
        begin : g_cell
            if (gi == TAP_SPAN - 1)
            begin : g_edge
                chu_cell u_cell (
                    .clk       (clk),
                    .ctl       (cell_ctl),
                    .fill_val  (chroma_sample),
                    .shift_val (right_in),
                    .sample    (window[gi])
                );
            end
            else
            begin : g_mid
                chu_cell u_cell (
                    .clk       (clk),
                    .ctl       (cell_ctl),
                    .fill_val  (chroma_sample),
                    .shift_val (window[gi+1]),
                    .sample    (window[gi])
                );
            end
        end
    endgenerate

    chu_filter u_filter (
        .window      (window),
        .mpeg2_mode  (mode_reg),
        .even_sample (filt_even),
        .odd_sample  (filt_odd)
    );

    // Next state of the row and flush control
    always_comb
    begin
        fill_count_next = fill_count_reg;
        flush_left_next = flush_left_reg;
        flush_n_next    = flush_n_reg;
        emit_pend_next  = emit_pend_reg && !emit_fire;
        emit_last_next  = emit_last_reg;
        if (accept)
        begin
            emit_pend_next = (fill_count_reg == FILL_FULL);
            emit_last_next = 1'b0;
            if (row_end)
            begin
                fill_count_next = 2'd0;
                flush_left_next = FLUSH_STEPS;
                flush_n_next    = fill_count_reg;
            end
            else if (fill_count_reg != FILL_FULL)
            begin
                fill_count_next = fill_count_reg + 2'd1;
            end
        end
        else if (flush_fire)
        begin
            flush_left_next = flush_left_reg - 2'd1;
            emit_pend_next  = flush_emit;
            emit_last_next  = (flush_left_reg == 2'd1);
        end
        out_valid_next = emit_fire || (out_valid_reg && pair_stall);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b1;
            fill_count_reg <= '0;
            flush_left_reg <= '0;
            flush_n_reg    <= '0;
            emit_pend_reg  <= 1'b0;
            emit_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            fill_count_reg <= fill_count_next;
            flush_left_reg <= flush_left_next;
            flush_n_reg    <= flush_n_next;
            emit_pend_reg  <= emit_pend_next;
            emit_last_reg  <= emit_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the output beat
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            even_reg <= filt_even;
            odd_reg  <= filt_odd;
            last_reg <= emit_last_reg;
        end
    end

    assign pair_valid  = out_valid_reg;
    assign even_sample = even_reg;
    assign odd_sample  = odd_reg;
    assign row_last    = last_reg;

endmodule

// ===== rtl/chu_cell.sv =====
// One window cell: holds a sample and takes its right neighbor's on a shift.
module chu_cell (
    input  logic               clk,
    input  chu_pkg::cell_ctl_t ctl,
    input  chu_pkg::sample_t   fill_val,
    input  chu_pkg::sample_t   shift_val,
    output chu_pkg::sample_t   sample
);
    import chu_pkg::*;

    sample_t sample_reg;

    // Load the row's first sample, or advance from the neighbor
    always_ff @(posedge clk)
    begin
        if (ctl.fill)
            sample_reg <= fill_val;
        else if (ctl.shift)
            sample_reg <= shift_val;
    end

    assign sample = sample_reg;

endmodule

// ===== rtl/chu_filter.sv =====
// Interpolation filters over the window: co-sited and interstitial modes.
module chu_filter (
    input  chu_pkg::window_t window,
    input  logic             mpeg2_mode,
    output chu_pkg::sample_t even_sample,
    output chu_pkg::sample_t odd_sample
);
    import chu_pkg::*;

    sum_t a, b, c, d, e, f, g;
    sum_t odd_cosited;
    sum_t even_inter;
    sum_t odd_inter;

    // Widen the window samples for signed arithmetic
    always_comb
    begin
        a = sum_t'(window[0]);
        b = sum_t'(window[1]);
        c = sum_t'(window[2]);
        d = sum_t'(window[3]);
        e = sum_t'(window[4]);
        f = sum_t'(window[5]);
        g = sum_t'(window[6]);
    end

    // Form the three filter sums
    always_comb
    begin
        odd_cosited = C21 * (b + g) - C52 * (c + f) + C159 * (d + e);
        even_inter  = C5 * a - C21 * b + C70 * c + C228 * d - C37 * e + C11 * f;
        odd_inter   = C5 * g - C21 * f + C70 * e + C228 * d - C37 * c + C11 * b;
    end

    // Select by mode; the co-sited even output copies the center sample
    always_comb
    begin
        if (mpeg2_mode)
        begin
            even_sample = window[3];
            odd_sample  = round_clamp(odd_cosited);
        end
        else
        begin
            even_sample = round_clamp(even_inter);
            odd_sample  = round_clamp(odd_inter);
        end
    end

endmodule
